@@ hdl/cgkl_pkg.sv @@
// Shared types and constants for the keyframe colour gradient block.
// No dependencies.
package cgkl_pkg;
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_EVAL  = 1'b1;
    localparam logic [31:0] WHITE_COLOR = 32'hFFFF_FFFF;
    localparam logic [17:0] TIME_SAT = 18'd131072;
    localparam logic [16:0] ONE_Q16 = 17'd65536;
    // Spans of 65 or less are at most 0.001 of the unit time.
    localparam logic [16:0] SPAN_MIN = 17'd65;

    typedef struct packed {
        logic load;       // capture the evaluate fields
        logic div_start;  // start the divider
        logic div_sel;    // 0: age / life, 1: offset / span
        logic seg_clr;    // restart the segment search
        logic rd_issue;   // read keyframe pair at the segment index
        logic k_zero;     // blend factor forced to zero
        logic blend_seg;  // lerp min and max bands
        logic blend_rnd;  // random lerp between them
    } cgkl_cmd_t;

    typedef struct packed {
        logic div_done;
        logic hit;        // current segment holds the time
        logic small_span;
        logic last_seg;   // no further segment within the count
    } cgkl_stat_t;

    function automatic logic [7:0] lerp8(input logic [7:0] a, input logic [7:0] b,
                                        input logic [16:0] k);
        logic [41:0] acc;
        acc = 42'(a) * 42'(ONE_Q16 - k) + 42'(b) * 42'(k) + 42'd32768;
        return acc[23:16];
    endfunction

    function automatic logic [31:0] lerp32(input logic [31:0] c0, input logic [31:0] c1,
                                          input logic [16:0] k);
        logic [31:0] r;
        for (int i = 0; i < 4; i++) r[i*8 +: 8] = lerp8(c0[i*8 +: 8], c1[i*8 +: 8], k);
        return r;
    endfunction
endpackage

@@ hdl/cgkl_div.sv @@
// Restoring divider, one quotient bit per cycle, 34-bit dividend, 17-bit divisor.
// Depends on cgkl_pkg.
module cgkl_div import cgkl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        start,
    input  logic [33:0] dividend,
    input  logic [16:0] divisor,
    output logic        done,
    output logic [33:0] quotient
);
    logic [33:0] q_reg, q_next;
    logic [17:0] r_reg, r_next;
    logic [16:0] d_reg;
    logic [5:0]  cnt_reg, cnt_next;
    logic        busy_reg, busy_next;
    logic [18:0] trial;

    always_comb begin
        q_next = q_reg;
        r_next = r_reg;
        cnt_next = cnt_reg;
        busy_next = busy_reg;
        trial = {r_reg, q_reg[33]} - {2'b0, d_reg};
        if (busy_reg) begin
            if (!trial[18]) begin
                r_next = trial[17:0];
                q_next = {q_reg[32:0], 1'b1};
            end else begin
                r_next = {r_reg[16:0], q_reg[33]};
                q_next = {q_reg[32:0], 1'b0};
            end
            cnt_next = cnt_reg - 6'd1;
            if (cnt_reg == 6'd1) busy_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            cnt_reg <= '0;
            done <= 1'b0;
        end else begin
            done <= busy_reg && (cnt_reg == 6'd1);
            if (start) begin
                busy_reg <= 1'b1;
                cnt_reg <= 6'd34;
            end else begin
                busy_reg <= busy_next;
                cnt_reg <= cnt_next;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            q_reg <= dividend;
            r_reg <= '0;
            d_reg <= divisor;
        end else begin
            q_reg <= q_next;
            r_reg <= r_next;
        end
    end

    assign quotient = q_reg;
endmodule

@@ hdl/cgkl_datapath.sv @@
// Datapath: keyframe memories, divider, segment compare and colour blends.
// Depends on cgkl_pkg and cgkl_div.
module cgkl_datapath import cgkl_pkg::*; #(
    parameter int MAX_KEYS = 16
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  cgkl_cmd_t   cmd,
    output cgkl_stat_t  stat,
    input  logic        wr_en,
    input  logic [3:0]  wr_index,
    input  logic [16:0] wr_time,
    input  logic [31:0] wr_min,
    input  logic [31:0] wr_max,
    input  logic [15:0] age,
    input  logic [15:0] life_span,
    input  logic [16:0] rand_factor,
    input  logic [4:0]  vertex_count,
    output logic [31:0] color
);
    localparam int IW = (MAX_KEYS > 1) ? $clog2(MAX_KEYS) : 1;

    logic [16:0] time_mem [MAX_KEYS];
    logic [31:0] min_mem [MAX_KEYS];
    logic [31:0] max_mem [MAX_KEYS];

    logic [16:0] from_reg, to_reg, rnd_reg, k_reg;
    logic [31:0] min0_reg, min1_reg, max0_reg, max1_reg, cmin_reg, cmax_reg, color_reg;
    logic [17:0] t_reg;
    logic [8:0]  seg_reg;
    logic [8:0]  count;
    logic [33:0] quot;
    logic        div_done;
    logic [33:0] dvd;
    logic [16:0] dvs;
    logic [16:0] span;

    always_ff @(posedge aclk) begin
        if (wr_en && ({28'd0, wr_index} < 32'(MAX_KEYS))) begin
            time_mem[IW'(wr_index)] <= wr_time;
            min_mem[IW'(wr_index)] <= wr_min;
            max_mem[IW'(wr_index)] <= wr_max;
        end
    end

    // Segment n reads entries n and n+1 into registers.
    always_ff @(posedge aclk) begin
        if (cmd.rd_issue) begin
            from_reg <= time_mem[seg_reg[IW-1:0]];
            min0_reg <= min_mem[seg_reg[IW-1:0]];
            max0_reg <= max_mem[seg_reg[IW-1:0]];
            to_reg <= time_mem[IW'(seg_reg + 9'd1)];
            min1_reg <= min_mem[IW'(seg_reg + 9'd1)];
            max1_reg <= max_mem[IW'(seg_reg + 9'd1)];
        end
    end

    assign count = (32'(vertex_count) > 32'(MAX_KEYS)) ? 9'(MAX_KEYS) : 9'(vertex_count);
    assign span = to_reg - from_reg;

    // The time division starts in the accepting cycle, so it takes the span from the port.
    always_comb begin
        if (!cmd.div_sel) begin
            dvd = {age, 18'd0} >> 2;
            dvs = {1'b0, (life_span == 16'd0) ? 16'd1 : life_span};
        end else begin
            dvd = {1'b0, 17'(t_reg - 18'(from_reg)), 16'd0};
            dvs = span;
        end
    end

    cgkl_div u_div (
        .aclk(aclk), .aresetn(aresetn), .start(cmd.div_start),
        .dividend(dvd), .divisor(dvs), .done(div_done), .quotient(quot)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            seg_reg <= '0;
        end else if (cmd.seg_clr) begin
            seg_reg <= '0;
        end else if (cmd.rd_issue) begin
            seg_reg <= seg_reg + 9'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            rnd_reg <= (rand_factor > ONE_Q16) ? ONE_Q16 : rand_factor;
        end
        if (div_done && !cmd.div_sel)
            t_reg <= (quot > 34'(TIME_SAT)) ? TIME_SAT : quot[17:0];
        if (cmd.k_zero) k_reg <= '0;
        else if (div_done && cmd.div_sel) k_reg <= quot[16:0];
        if (cmd.blend_seg) begin
            cmin_reg <= lerp32(min0_reg, min1_reg, k_reg);
            cmax_reg <= lerp32(max0_reg, max1_reg, k_reg);
        end
        if (cmd.blend_rnd) color_reg <= lerp32(cmin_reg, cmax_reg, rnd_reg);
    end

    assign stat.div_done = div_done;
    assign stat.hit = (t_reg >= 18'(from_reg)) && (t_reg <= 18'(to_reg));
    assign stat.small_span = span <= SPAN_MIN;
    assign stat.last_seg = (seg_reg + 9'd1) >= count;
    assign color = color_reg;
endmodule

@@ hdl/cgkl_ctrl.sv @@
// Controller state machine sequencing the evaluation and the result handshake.
// Depends on cgkl_pkg.
module cgkl_ctrl import cgkl_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        in_valid,
    input  logic        in_cmd,
    input  logic        few_keys,
    output logic        in_ready,
    output logic        wr_en,
    output cgkl_cmd_t   cmd,
    input  cgkl_stat_t  stat,
    input  logic [31:0] color,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_color,
    output logic        out_matched
);
    typedef enum logic [3:0] {
        S_IDLE, S_TDIV, S_READ, S_CHECK, S_KDIV, S_BLEND1, S_BLEND2, S_DONE
    } state_t;

    state_t state_reg;
    logic   pend_reg;

    assign in_ready = (state_reg == S_IDLE) && !out_valid;
    assign wr_en = in_valid && in_ready && (in_cmd == CMD_WRITE);

    always_comb begin
        cmd = '0;
        cmd.load = in_valid && in_ready && (in_cmd == CMD_EVAL);
        cmd.div_start = cmd.load;
        cmd.div_sel = (state_reg == S_KDIV) || (state_reg == S_CHECK);
        cmd.seg_clr = cmd.load;
        cmd.rd_issue = (state_reg == S_READ);
        cmd.k_zero = (state_reg == S_CHECK) && stat.hit && stat.small_span;
        if ((state_reg == S_CHECK) && stat.hit && !stat.small_span) cmd.div_start = 1'b1;
        cmd.blend_seg = (state_reg == S_BLEND1);
        cmd.blend_rnd = (state_reg == S_BLEND2);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            out_valid <= 1'b0;
            out_color <= '0;
            out_matched <= 1'b0;
            pend_reg <= 1'b0;
        end else begin
            if (out_valid && out_ready) out_valid <= 1'b0;
            case (state_reg)
                S_IDLE: begin
                    if (in_valid && in_ready) begin
                        if (in_cmd == CMD_WRITE) begin
                            out_valid <= 1'b1;
                            out_color <= '0;
                            out_matched <= 1'b0;
                        end else begin
                            pend_reg <= few_keys;
                            state_reg <= S_TDIV;
                        end
                    end
                end
                S_TDIV: begin
                    if (stat.div_done) begin
                        if (pend_reg) begin
                            out_valid <= 1'b1;
                            out_color <= WHITE_COLOR;
                            out_matched <= 1'b0;
                            state_reg <= S_IDLE;
                        end else begin
                            state_reg <= S_READ;
                        end
                    end
                end
                S_READ: state_reg <= S_CHECK;
                S_CHECK: begin
                    if (stat.hit) begin
                        state_reg <= stat.small_span ? S_BLEND1 : S_KDIV;
                    end else if (stat.last_seg) begin
                        out_valid <= 1'b1;
                        out_color <= WHITE_COLOR;
                        out_matched <= 1'b0;
                        state_reg <= S_IDLE;
                    end else begin
                        state_reg <= S_READ;
                    end
                end
                S_KDIV: if (stat.div_done) state_reg <= S_BLEND1;
                S_BLEND1: state_reg <= S_BLEND2;
                S_BLEND2: state_reg <= S_DONE;
                S_DONE: begin
                    out_valid <= 1'b1;
                    out_color <= color;
                    out_matched <= 1'b1;
                    state_reg <= S_IDLE;
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end
endmodule

@@ hdl/color_gradient_keyframe_lerp_top.sv @@
// Top level of the keyframe colour gradient block: controller and datapath.
// Depends on cgkl_pkg, cgkl_ctrl and cgkl_datapath.
//
//  Channel  Direction  Contents
//  s_axis   in         tuser cmd; tdata key_index, key_time, colours, age, span, rand
//  m_axis   out        tdata color_out; tuser matched
//  cfg      in         vertex_count, written by cfg_wr_en
//
// A write transaction returns a zero result. An evaluation runs the time division,
// then reads and compares each segment searched, runs the blend-factor division when
// the span is not tiny, and blends and presents the result; the serial divider sets
// most of the evaluation time. One transaction is in flight at a time; a stalled
// result holds off the next input.
// Reset clears the controller and the keyframe count; keyframes are undefined.
module color_gradient_keyframe_lerp_top import cgkl_pkg::*; #(
    parameter int MAX_KEYS = 16
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_axis_tvalid,
    output logic         s_axis_tready,
    // tdata: key_index[3:0], key_time[20:4], key_min_color[52:21],
    // key_max_color[84:53], age[100:85], life_span[116:101], rand_factor[133:117]
    input  logic [135:0] s_axis_tdata,
    // tuser: cmd
    input  logic         s_axis_tuser,
    output logic         m_axis_tvalid,
    input  logic         m_axis_tready,
    // tdata: color_out[31:0]
    output logic [31:0]  m_axis_tdata,
    // tuser: matched
    output logic         m_axis_tuser,
    input  logic         cfg_wr_en,
    input  logic [4:0]   cfg_wr_data
);
    logic [4:0] vcount_reg;
    cgkl_cmd_t  cmd;
    cgkl_stat_t stat;
    logic       wr_en;
    logic [31:0] color;

    always_ff @(posedge aclk) begin
        if (!aresetn) vcount_reg <= '0;
        else if (cfg_wr_en) vcount_reg <= cfg_wr_data;
    end

    cgkl_ctrl u_ctrl (
        .aclk(aclk), .aresetn(aresetn),
        .in_valid(s_axis_tvalid), .in_cmd(s_axis_tuser),
        .few_keys(vcount_reg < 5'd2),
        .in_ready(s_axis_tready), .wr_en(wr_en), .cmd(cmd), .stat(stat), .color(color),
        .out_valid(m_axis_tvalid), .out_ready(m_axis_tready),
        .out_color(m_axis_tdata), .out_matched(m_axis_tuser)
    );

    cgkl_datapath #(.MAX_KEYS(MAX_KEYS)) u_dp (
        .aclk(aclk), .aresetn(aresetn), .cmd(cmd), .stat(stat),
        .wr_en(wr_en), .wr_index(s_axis_tdata[3:0]), .wr_time(s_axis_tdata[20:4]),
        .wr_min(s_axis_tdata[52:21]), .wr_max(s_axis_tdata[84:53]),
        .age(s_axis_tdata[100:85]), .life_span(s_axis_tdata[116:101]),
        .rand_factor(s_axis_tdata[133:117]), .vertex_count(vcount_reg), .color(color)
    );

    a_no_accept_while_out: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> !s_axis_tready) else $error("input taken with result pending");
    a_write_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        (s_axis_tvalid && s_axis_tready && !s_axis_tuser)
        |=> (m_axis_tvalid && m_axis_tdata == 32'd0))
        else $error("write result wrong");
    a_unmatched_white: assert property (@(posedge aclk) disable iff (!aresetn)
        (m_axis_tvalid && !m_axis_tuser && m_axis_tdata != 32'd0)
        |-> m_axis_tdata == WHITE_COLOR)
        else $error("unmatched result not white");
endmodule
